// ----- hdl/dmrb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmrb_pkg: shared types and constants for the dual motor ramp bridge drive
// Register map, input kinds, level and configuration types.
// ----------------------------------------------------------------------------
package dmrb_pkg;

    localparam int FULL_SCALE         = 255;
    localparam int DEADBAND           = 18;
    localparam int RAMP_PERIOD_MS     = 10;
    localparam int MAX_STEPS_PER_TICK = 4;

    localparam int STEP_CNT_W = $clog2(MAX_STEPS_PER_TICK + 1);

    // input kinds carried in s_tuser
    localparam logic [2:0] KIND_SET_LEFT  = 3'd0;
    localparam logic [2:0] KIND_SET_RIGHT = 3'd1;
    localparam logic [2:0] KIND_SET_BOTH  = 3'd2;
    localparam logic [2:0] KIND_STOP      = 3'd3;
    localparam logic [2:0] KIND_TICK      = 3'd4;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_MAX_PWM    = 2'd0;
    localparam logic [1:0] REG_ACCEL_STEP = 2'd1;
    localparam logic [1:0] REG_BRAKE_STEP = 2'd2;

    typedef logic signed [8:0] level_t;
    typedef logic [7:0]        duty_t;

    // effective register values, zero already replaced by one
    typedef struct packed {
        logic [7:0] max_pwm;
        logic [7:0] accel_step;
        logic [7:0] brake_step;
    } cfg_t;

endpackage

// ----- hdl/dual_motor_ramp_bridge_drive.sv -----
// ----------------------------------------------------------------------------
// dual_motor_ramp_bridge_drive: two-channel slew-limited H-bridge drive
// Sequencer around one shared scaler and one shared level stepper.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_t*: s_tuser is the kind (set left, set right, set both,
//   stop, tick); s_tdata carries both speeds and the millisecond time.
//   Output words on m_t* carry both duty pairs and both ramped levels.
//   Set words give no output. Stop clears the levels and gives an all-zero
//   output word from the output state. A tick gives no output when less
//   than 10 ms have passed since the last ramp (busy only in the tick
//   state); otherwise the levels step 1 to 4 times and one word is issued.
//   A ramp tick passes through the tick, target (TGT0 to TGT2), step and
//   output states: the single stepper handles one side per cycle, and the
//   scaler yields both targets through its registered multiplier.
//   s_tready is high only while the sequencer is idle. A finished word sits
//   in the output register while the next input word is taken; a stalled
//   receiver holds the sequencer in its output state until the register
//   frees up.
//   Reset clears commands, levels, the ramp time and the output valid, and
//   sets max_pwm to 255 and both step sizes to 1. The user must write APB
//   registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_motor_ramp_bridge_drive
    import dmrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // left_speed[8:0], right_speed[17:9], now_ms[49:18]
    input  logic [2:0]  s_tuser,  // kind[2:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // a_forward_duty[7:0], a_reverse_duty[15:8],
                                  // b_forward_duty[23:16], b_reverse_duty[31:24],
                                  // left_level[40:32], right_level[49:41]
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_TGT0 = 3'd2;
    localparam logic [2:0] ST_TGT1 = 3'd3;
    localparam logic [2:0] ST_TGT2 = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    cfg_t cfg;

    logic [2:0]            state_reg, state_next;
    level_t                left_cmd_reg, left_cmd_next;
    level_t                right_cmd_reg, right_cmd_next;
    level_t                left_drive_reg, left_drive_next;
    level_t                right_drive_reg, right_drive_next;
    level_t                left_tgt_reg, left_tgt_next;
    level_t                right_tgt_reg, right_tgt_next;
    logic [31:0]           last_ramp_reg, last_ramp_next;
    logic [31:0]           now_reg, now_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  side_reg, side_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [55:0]           m_tdata_reg, m_tdata_next;

    logic                  accept;
    logic                  out_free;
    level_t                in_left, in_right;
    logic [31:0]           elapsed;
    level_t                scale_cmd, scale_tgt;
    level_t                step_cur, step_tgt, step_nxt;
    duty_t                 a_fwd, a_rev, b_fwd, b_rev;

    dmrb_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmrb_scale u_scale (
        .clk     (clk),
        .cmd     (scale_cmd),
        .max_pwm (cfg.max_pwm),
        .target  (scale_tgt)
    );

    dmrb_stepper u_stepper (
        .cur (step_cur),
        .tgt (step_tgt),
        .cfg (cfg),
        .nxt (step_nxt)
    );

    function automatic level_t sat_in(input logic [8:0] v);
        // only -256 lies outside +/-255
        sat_in = (v == 9'h100) ? 9'sh101 : $signed(v);
    endfunction

    function automatic duty_t fwd_of(input level_t lvl);
        fwd_of = (lvl >= 9'sd18) ? lvl[7:0] : 8'd0;
    endfunction

    function automatic duty_t rev_of(input level_t lvl);
        level_t neg;
        neg    = -lvl;
        rev_of = (lvl <= -9'sd18) ? neg[7:0] : 8'd0;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_left  = sat_in(s_tdata[8:0]);
    assign in_right = sat_in(s_tdata[17:9]);
    assign elapsed  = now_reg - last_ramp_reg;

    assign scale_cmd = (state_reg == ST_TGT0) ? left_cmd_reg : right_cmd_reg;
    assign step_cur  = side_reg ? right_drive_reg : left_drive_reg;
    assign step_tgt  = side_reg ? right_tgt_reg : left_tgt_reg;

    assign a_fwd = fwd_of(left_drive_reg);
    assign a_rev = rev_of(left_drive_reg);
    assign b_fwd = fwd_of(right_drive_reg);
    assign b_rev = rev_of(right_drive_reg);

    always_comb
    begin
        state_next       = state_reg;
        left_cmd_next    = left_cmd_reg;
        right_cmd_next   = right_cmd_reg;
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;
        left_tgt_next    = left_tgt_reg;
        right_tgt_next   = right_tgt_reg;
        last_ramp_next   = last_ramp_reg;
        now_next         = now_reg;
        cnt_next         = cnt_reg;
        side_next        = side_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        KIND_SET_LEFT:
                            left_cmd_next = in_left;
                        KIND_SET_RIGHT:
                            right_cmd_next = in_right;
                        KIND_SET_BOTH:
                        begin
                            left_cmd_next  = in_left;
                            right_cmd_next = in_right;
                        end
                        KIND_STOP:
                        begin
                            left_cmd_next    = '0;
                            right_cmd_next   = '0;
                            left_drive_next  = '0;
                            right_drive_next = '0;
                            state_next       = ST_OUT;
                        end
                        KIND_TICK:
                        begin
                            now_next   = s_tdata[49:18];
                            state_next = ST_TICK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (elapsed < 32'(RAMP_PERIOD_MS))
                    state_next = ST_IDLE;
                else
                begin
                    last_ramp_next = now_reg;
                    // step count = min(elapsed / period, max steps), one compare per count
                    for (int k = 1; k <= MAX_STEPS_PER_TICK; k++)
                    begin
                        if (elapsed >= 32'(k * RAMP_PERIOD_MS))
                            cnt_next = STEP_CNT_W'(k);
                    end
                    side_next  = 1'b0;
                    state_next = ST_TGT0;
                end
            end
            ST_TGT0:
                state_next = ST_TGT1;
            ST_TGT1:
            begin
                left_tgt_next = scale_tgt;
                state_next    = ST_TGT2;
            end
            ST_TGT2:
            begin
                right_tgt_next = scale_tgt;
                state_next     = ST_STEP;
            end
            ST_STEP:
            begin
                if (!side_reg)
                begin
                    left_drive_next = step_nxt;
                    side_next       = 1'b1;
                end
                else
                begin
                    right_drive_next = step_nxt;
                    side_next        = 1'b0;
                    cnt_next         = cnt_reg - STEP_CNT_W'(1);
                    if (cnt_reg == STEP_CNT_W'(1))
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, right_drive_reg, left_drive_reg,
                                     b_rev, b_fwd, a_rev, a_fwd};
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            left_cmd_reg    <= '0;
            right_cmd_reg   <= '0;
            left_drive_reg  <= '0;
            right_drive_reg <= '0;
            last_ramp_reg   <= '0;
            cnt_reg         <= '0;
            side_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            left_cmd_reg    <= left_cmd_next;
            right_cmd_reg   <= right_cmd_next;
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
            last_ramp_reg   <= last_ramp_next;
            cnt_reg         <= cnt_next;
            side_reg        <= side_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_tgt_reg  <= left_tgt_next;
        right_tgt_reg <= right_tgt_next;
        now_reg       <= now_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_drive_reg != 9'sh100 && right_drive_reg != 9'sh100)
        else $error("drive level outside +/-255");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == KIND_STOP) |=>
        (state_reg == ST_OUT && left_drive_reg == '0 && right_drive_reg == '0))
        else $error("stop did not clear levels");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> (cnt_reg != '0 && cnt_reg <= STEP_CNT_W'(MAX_STEPS_PER_TICK)))
        else $error("step count out of range while stepping");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output word loaded outside output state");
`endif

endmodule

// ----- hdl/dmrb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dmrb_cfg_regs: APB register file
// Holds max_pwm, accel_step and brake_step; presents them with zero as one.
// ----------------------------------------------------------------------------
module dmrb_cfg_regs
    import dmrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] max_pwm_reg;
    logic [7:0] accel_step_reg;
    logic [7:0] brake_step_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pwm_reg    <= 8'd255;
            accel_step_reg <= 8'd1;
            brake_step_reg <= 8'd1;
        end
        else if (wr_en)
        begin
            if (idx == REG_MAX_PWM)
                max_pwm_reg <= pwdata[7:0];
            if (idx == REG_ACCEL_STEP)
                accel_step_reg <= pwdata[7:0];
            if (idx == REG_BRAKE_STEP)
                brake_step_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (idx == REG_MAX_PWM)
            prdata = {24'd0, max_pwm_reg};
        else if (idx == REG_ACCEL_STEP)
            prdata = {24'd0, accel_step_reg};
        else if (idx == REG_BRAKE_STEP)
            prdata = {24'd0, brake_step_reg};
    end

    assign cfg.max_pwm    = (max_pwm_reg == 8'd0)    ? 8'd1 : max_pwm_reg;
    assign cfg.accel_step = (accel_step_reg == 8'd0) ? 8'd1 : accel_step_reg;
    assign cfg.brake_step = (brake_step_reg == 8'd0) ? 8'd1 : brake_step_reg;

endmodule

// ----- hdl/dmrb_scale.sv -----
// ----------------------------------------------------------------------------
// dmrb_scale: command to target level
// Registered 8x8 product, then divide by 255 with a shift-add reciprocal.
// The target for a command appears in the next cycle.
// ----------------------------------------------------------------------------
module dmrb_scale
    import dmrb_pkg::*;
(
    input  logic       clk,
    input  level_t     cmd,
    input  logic [7:0] max_pwm,
    output level_t     target
);

    logic [7:0]  mag;
    logic [15:0] prod_reg;
    logic        neg_reg;
    logic        dead_reg;
    logic [16:0] sum;
    logic [7:0]  quo;

    // cmd is already saturated to +/-255, so the magnitude fits 8 bits
    assign mag = cmd[8] ? 8'(-cmd) : cmd[7:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= {8'd0, mag} * {8'd0, max_pwm};
        neg_reg  <= cmd[8];
        dead_reg <= (mag < 8'(DEADBAND));
    end

    // floor(x/255) = (x + (x >> 8) + 1) >> 8 for x up to 255*255
    assign sum = {1'b0, prod_reg} + {9'd0, prod_reg[15:8]} + 17'd1;
    assign quo = sum[15:8];

    always_comb
    begin
        if (dead_reg)
            target = '0;
        else if (neg_reg)
            target = -$signed({1'b0, quo});
        else
            target = $signed({1'b0, quo});
    end

endmodule

// ----- hdl/dmrb_stepper.sv -----
// ----------------------------------------------------------------------------
// dmrb_stepper: one slew step of a drive level toward its target
// Brake step when heading to zero or slowing, accel step otherwise.
// ----------------------------------------------------------------------------
module dmrb_stepper
    import dmrb_pkg::*;
(
    input  level_t cur,
    input  level_t tgt,
    input  cfg_t   cfg,
    output level_t nxt
);

    logic signed [9:0] delta;
    logic [9:0]        adelta;
    logic              braking;
    logic [7:0]        step;
    logic signed [9:0] moved;

    assign delta   = {tgt[8], tgt} - {cur[8], cur};
    assign adelta  = delta[9] ? 10'(-delta) : 10'(delta);
    assign braking = (tgt == '0) || (cur > 0 && tgt < cur) || (cur < 0 && tgt > cur);
    assign step    = braking ? cfg.brake_step : cfg.accel_step;
    assign moved   = delta[9] ? ({cur[8], cur} - $signed({2'b0, step}))
                              : ({cur[8], cur} + $signed({2'b0, step}));

    // step is never zero, so an equal level lands on the target here too
    assign nxt = (adelta <= {2'b0, step}) ? tgt : moved[8:0];

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for dual_motor_ramp_bridge_drive
// Drives set, stop, tick and spare-kind words on the input stream and
// reprograms the APB registers between phases. A behavioral model predicts
// every output word, and each output word is checked field by field.
// Both stream sides idle at random, except in the stall-free phase.
// ----------------------------------------------------------------------------
module tb;
    import dmrb_pkg::*;

    typedef struct packed {
        duty_t  a_fwd;
        duty_t  a_rev;
        duty_t  b_fwd;
        duty_t  b_rev;
        level_t left_level;
        level_t right_level;
    } bridge_word_t;

    localparam logic [1:0] REG_UNUSED   = 2'd3;
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int         DRAIN_CYCLES = 24;
    localparam int         IDLE_PCT     = 38;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;  // left_speed[8:0], right_speed[17:9], now_ms[49:18]
    logic [2:0]  s_tuser  = '0;  // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // a_fwd[7:0], a_rev[15:8], b_fwd[23:16], b_rev[31:24],
                                 // left_level[40:32], right_level[49:41]

    // model state
    logic [7:0]   cfg_max_pwm;
    logic [7:0]   cfg_accel;
    logic [7:0]   cfg_brake;
    int           left_cmd;
    int           right_cmd;
    int           left_lvl;
    int           right_lvl;
    logic [31:0]  last_ramp_ms;
    bridge_word_t pending_words[$];

    int          err_count  = 0;
    logic [31:0] clock_ms   = '0;
    bit          stall_free = 1'b0;

    dual_motor_ramp_bridge_drive u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- model
    function automatic int clamp_fs(int v);
        if (v > FULL_SCALE)
            return FULL_SCALE;
        if (v < -FULL_SCALE)
            return -FULL_SCALE;
        return v;
    endfunction

    function automatic int nonzero(logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    function automatic int drive_target(int cmd);
        int s;
        int mag;
        s = clamp_fs(cmd);
        if (s > -DEADBAND && s < DEADBAND)
            return 0;
        mag = ((s < 0) ? -s : s) * nonzero(cfg_max_pwm) / FULL_SCALE;
        return (s >= 0) ? mag : -mag;
    endfunction

    function automatic int ramp_once(int cur, int tgt);
        int  delta;
        int  step;
        int  adelta;
        bit  braking;
        if (cur == tgt)
            return cur;
        delta   = tgt - cur;
        braking = (tgt == 0) || (cur > 0 && tgt < cur) || (cur < 0 && tgt > cur);
        step    = braking ? nonzero(cfg_brake) : nonzero(cfg_accel);
        adelta  = (delta < 0) ? -delta : delta;
        if (adelta <= step)
            return tgt;
        return cur + ((delta > 0) ? step : -step);
    endfunction

    function automatic void duty_pair(input int lvl, output duty_t fwd, output duty_t rev);
        int s;
        s   = clamp_fs(lvl);
        fwd = '0;
        rev = '0;
        if (s > -DEADBAND && s < DEADBAND)
            return;
        if (s > 0)
            fwd = duty_t'(s);
        else
            rev = duty_t'(-s);
    endfunction

    function automatic bridge_word_t bridge_snapshot();
        bridge_word_t w;
        duty_pair(left_lvl, w.a_fwd, w.a_rev);
        duty_pair(right_lvl, w.b_fwd, w.b_rev);
        w.left_level  = level_t'(left_lvl);
        w.right_level = level_t'(right_lvl);
        return w;
    endfunction

    task automatic model_accept(input logic [2:0] kind, input logic [8:0] ls,
                                input logic [8:0] rs, input logic [31:0] now);
        int          ls_i;
        int          rs_i;
        logic [31:0] elapsed;
        logic [31:0] steps;
        ls_i = clamp_fs(int'($signed(ls)));
        rs_i = clamp_fs(int'($signed(rs)));
        case (kind)
            KIND_SET_LEFT:  left_cmd = ls_i;
            KIND_SET_RIGHT: right_cmd = rs_i;
            KIND_SET_BOTH:
            begin
                left_cmd  = ls_i;
                right_cmd = rs_i;
            end
            KIND_STOP:
            begin
                left_cmd  = 0;
                right_cmd = 0;
                left_lvl  = 0;
                right_lvl = 0;
                pending_words.push_back(bridge_snapshot());
            end
            KIND_TICK:
            begin
                elapsed = now - last_ramp_ms;
                if (elapsed >= RAMP_PERIOD_MS)
                begin
                    steps = elapsed / RAMP_PERIOD_MS;
                    if (steps > MAX_STEPS_PER_TICK)
                        steps = MAX_STEPS_PER_TICK;
                    last_ramp_ms = now;
                    for (int i = 0; i < int'(steps); i++)
                    begin
                        left_lvl  = ramp_once(left_lvl, drive_target(left_cmd));
                        right_lvl = ramp_once(right_lvl, drive_target(right_cmd));
                    end
                    pending_words.push_back(bridge_snapshot());
                end
            end
            default: ;  // spare kinds are dropped
        endcase
    endtask

    // ---------------------------------------------------------------- checker
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_words
        bridge_word_t want;
        bridge_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.a_fwd       = m_tdata[7:0];
            got.a_rev       = m_tdata[15:8];
            got.b_fwd       = m_tdata[23:16];
            got.b_rev       = m_tdata[31:24];
            got.left_level  = m_tdata[40:32];
            got.right_level = m_tdata[49:41];
            if (pending_words.size() == 0)
            begin
                $error("output word with nothing expected: %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("a_forward_duty", want.a_fwd, got.a_fwd);
                check_field("a_reverse_duty", want.a_rev, got.a_rev);
                check_field("b_forward_duty", want.b_fwd, got.b_fwd);
                check_field("b_reverse_duty", want.b_rev, got.b_rev);
                check_field("left_level", want.left_level, got.left_level);
                check_field("right_level", want.right_level, got.right_level);
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
        m_tready = stall_free || ($urandom_range(99) >= IDLE_PCT);

    // ---------------------------------------------------------------- drivers
    task automatic send_word(input logic [2:0] kind, input logic [8:0] ls,
                             input logic [8:0] rs, input logic [31:0] now);
        @(negedge clk);
        if (!stall_free)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {6'b0, now, rs, ls};
        do
            @(posedge clk);
        while (!s_tready);
        model_accept(kind, ls, rs, now);
    endtask

    // stop sending and let every pending word and any busy tick finish
    task automatic drain_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MAX_PWM:    cfg_max_pwm = val[7:0];
            REG_ACCEL_STEP: cfg_accel   = val[7:0];
            REG_BRAKE_STEP: cfg_brake   = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] mx, input logic [7:0] ac, input logic [7:0] br);
        drain_block();
        reg_write(REG_MAX_PWM, {24'b0, mx});
        reg_write(REG_ACCEL_STEP, {24'b0, ac});
        reg_write(REG_BRAKE_STEP, {24'b0, br});
    endtask

    function automatic logic [8:0] pick_speed();
        int r;
        int mag;
        r = $urandom_range(99);
        if (r < 50)
            return 9'($urandom);
        if (r < 75)
        begin
            case ($urandom_range(3))
                0:       return 9'h100;   // -256
                1:       return 9'h101;   // -255
                2:       return 9'd255;
                default: return 9'd0;
            endcase
        end
        mag = $urandom_range(14, 22);     // around the deadband edge
        return $urandom_range(1) ? 9'(mag) : 9'(-mag);
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_default_ramp();
        send_word(KIND_SET_BOTH, 9'd255, 9'h100, $urandom);
        send_word(KIND_TICK, 9'h000, 9'h1FF, 32'd4);       // too early, no word
        send_word(KIND_TICK, 9'h1FF, 9'h000, 32'd10);      // one step
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1000);    // capped at four steps
        send_word(KIND_SET_LEFT, 9'd17, 9'h1FF, 32'hFFFF_FFFF);
        send_word(KIND_SET_RIGHT, 9'h000, 9'd18, 32'h0);
        send_word(KIND_TICK, 9'h0AA, 9'h155, 32'd1010);
    endtask

    task automatic test_spare_kinds();
        send_word(KIND_SPARE_A, 9'd255, 9'd255, 32'hFFFF_FFFF);
        send_word(KIND_SPARE_B, 9'h100, 9'h100, 32'd5000);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1021);
    endtask

    task automatic test_stop();
        send_word(KIND_STOP, 9'h1FF, 9'h1FF, $urandom);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1032);
    endtask

    task automatic test_register_extremes();
        set_regs(8'd1, 8'd255, 8'd255);
        reg_write(REG_UNUSED, 32'hFFFF_FFAB);               // no register here
        send_word(KIND_SET_BOTH, 9'h1EE, 9'd255, $urandom); // -18 and full
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1045);
        set_regs(8'd255, 8'd255, 8'd0);                     // zero acts as one
        send_word(KIND_SET_BOTH, 9'h101, 9'd255, $urandom);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1060);
        send_word(KIND_SET_BOTH, 9'd0, 9'd0, $urandom);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'd1075);
        set_regs(8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_time_wrap();
        send_word(KIND_SET_BOTH, 9'd255, 9'h100, $urandom);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'hFFFF_FFF8);
        send_word(KIND_TICK, 9'h000, 9'h000, 32'h0000_0004); // 12 ms across the wrap
        send_word(KIND_STOP, 9'h000, 9'h000, $urandom);
        clock_ms = 32'h0000_0004;
    endtask

    task automatic test_random_phase(input int n_items, input logic [7:0] mx,
                                     input logic [7:0] ac, input logic [7:0] br,
                                     input bit calm);
        int          sent;
        int          pick;
        int          gap_pick;
        logic [31:0] gap_ms;
        set_regs(mx, ac, br);
        stall_free = calm;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(199) == 0)
                drain_block();
            pick = $urandom_range(99);
            if (pick >= 48 && pick < 53)
                send_word(3'($urandom_range(5, 7)), 9'($urandom), 9'($urandom), $urandom);
            else if (pick < 15)
                send_word(KIND_SET_LEFT, pick_speed(), 9'($urandom), $urandom);
            else if (pick < 30)
                send_word(KIND_SET_RIGHT, 9'($urandom), pick_speed(), $urandom);
            else if (pick < 45)
                send_word(KIND_SET_BOTH, pick_speed(), pick_speed(), $urandom);
            else if (pick < 48)
                send_word(KIND_STOP, 9'($urandom), 9'($urandom), $urandom);
            else
            begin
                gap_pick = $urandom_range(99);
                if (gap_pick < 10)
                    gap_ms = $urandom_range(0, 9);
                else if (gap_pick < 85)
                    gap_ms = $urandom_range(10, 45);
                else if (gap_pick < 95)
                    gap_ms = $urandom_range(46, 400);
                else
                    gap_ms = $urandom;
                clock_ms = clock_ms + gap_ms;
                send_word(KIND_TICK, 9'($urandom), 9'($urandom), clock_ms);
            end
            sent++;
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        cfg_max_pwm  = 8'd255;
        cfg_accel    = 8'd1;
        cfg_brake    = 8'd1;
        left_cmd     = 0;
        right_cmd    = 0;
        left_lvl     = 0;
        right_lvl    = 0;
        last_ramp_ms = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_ramp();
        test_spare_kinds();
        test_stop();
        test_register_extremes();
        test_time_wrap();

        test_random_phase(305, 8'd255, 8'd1, 8'd1, 1'b0);
        test_random_phase(305, 8'd255, 8'd255, 8'd255, 1'b0);
        test_random_phase(305, 8'd1, 8'd1, 8'd1, 1'b0);
        test_random_phase(305, 8'd128, 8'd20, 8'd60, 1'b1);
        test_random_phase(305, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 255)), 1'b0);
        test_random_phase(305, 8'd200, 8'd7, 8'd3, 1'b0);

        drain_block();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
